>>> rtl/grouped_token_bucket_limiter_assert.svh
// Assertion macros for the grouped token bucket limiter.
`ifndef GROUPED_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define GROUPED_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when a holds, c holds.
`define GTB_ASSERT_IMPLY(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gtb: same-cycle check failed");
// Next-cycle implication: when a holds, c holds in the next cycle.
`define GTB_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gtb: next-cycle check failed");
`else
`define GTB_ASSERT_IMPLY(lbl, clk, rst, a, c)
`define GTB_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> rtl/gtb_pkg.sv
// Shared types and constants for the grouped token bucket limiter.
package gtb_pkg;

  localparam int NUM_GROUPS = 4;
  localparam int MAX_GROUPS = 4;
  localparam int GIDX_W     = $clog2(MAX_GROUPS);
  localparam int GRP_W      = 3;
  localparam int TOK_W      = 32;
  localparam int TOK_EXT_W  = TOK_W + 1;
  localparam int TIME_W     = 64;
  localparam int HALF_W     = 32;
  localparam int PROD_W     = TIME_W + TOK_W;

  // Division by one billion through a reciprocal scaled by 2^RECIP_SHIFT.
  localparam int NS_W        = 30;
  localparam int RECIP_SHIFT = 62;
  localparam int P_W         = RECIP_SHIFT;
  localparam int RECIP_W     = 33;
  localparam int A_W         = HALF_W + RECIP_W;
  localparam int B_W         = (P_W - HALF_W) + RECIP_W;
  localparam int S_W         = B_W + HALF_W;
  localparam logic [NS_W-1:0]    NS_PER_SEC = NS_W'(1000000000);
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(64'd4611686018);

  localparam int PIPE_DEPTH = 9;

  // Configuration register map.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BASE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BASE = CFG_IDX_W'(MAX_GROUPS);
  localparam logic [CFG_IDX_W-1:0] REG_END         = CFG_IDX_W'(2 * MAX_GROUPS);

  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last;
  } state_word_t;

  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] idx;
    state_word_t       word;
  } wb_t;

  typedef struct packed {
    logic              lim;
    logic [GIDX_W-1:0] idx;
    logic [TOK_W-1:0]  bytes;
    logic [TIME_W-1:0] now;
    logic [TOK_W-1:0]  rate;
    logic [TOK_W-1:0]  bucket;
  } req_t;

  typedef struct packed {
    logic              lim;
    logic [GIDX_W-1:0] idx;
    logic [TOK_W-1:0]  bytes;
    logic [TIME_W-1:0] now;
    logic [TOK_W-1:0]  bucket;
    logic [TOK_W-1:0]  tok_old;
  } item_t;

  typedef struct packed {
    logic                  in_free;
    logic                  empty;
    logic [MAX_GROUPS-1:0] busy;
  } pipe_status_t;

endpackage

>>> rtl/gtb_ifs.sv
// Handshake channel interfaces: request, result and configuration.
interface gtb_req_if import gtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRP_W-1:0]  group_number;
  logic [TOK_W-1:0]  byte_count;
  logic [TIME_W-1:0] time_now_ns;
  modport source (output valid, group_number, byte_count, time_now_ns, input ready);
  modport sink (input valid, group_number, byte_count, time_now_ns, output ready);
endinterface

interface gtb_res_if import gtb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             allowed;
  logic [TOK_W-1:0] tokens_left;
  modport source (output valid, allowed, tokens_left, input ready);
  modport sink (input valid, allowed, tokens_left, output ready);
endinterface

interface gtb_cfg_if import gtb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TOK_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gtb_cfg_regs.sv
// Rate and bucket configuration registers with a per-group lookup.
module gtb_cfg_regs import gtb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  gtb_cfg_if.sink           cfg,
  input  logic [GIDX_W-1:0] idx,
  output logic [TOK_W-1:0]  rate,
  output logic [TOK_W-1:0]  bucket
);

  logic [TOK_W-1:0] rate_reg   [MAX_GROUPS];
  logic [TOK_W-1:0] bucket_reg [MAX_GROUPS];

  assign cfg.ready = 1'b1;

  // Ignore writes beyond the register map.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        rate_reg[g]   <= '0;
        bucket_reg[g] <= '0;
      end
    end else if (cfg.valid) begin
      if (cfg.index < REG_BUCKET_BASE) begin
        rate_reg[GIDX_W'(cfg.index - REG_RATE_BASE)] <= cfg.data;
      end else if (cfg.index < REG_END) begin
        bucket_reg[GIDX_W'(cfg.index - REG_BUCKET_BASE)] <= cfg.data;
      end
    end
  end

  assign rate   = rate_reg[idx];
  assign bucket = bucket_reg[idx];

endmodule

>>> rtl/gtb_state_ram.sv
// Per-group token and timestamp memory with a registered read, entries read as zero until written.
module gtb_state_ram import gtb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [GIDX_W-1:0] rd_idx,
  output state_word_t       rd_word,
  input  wb_t               wb
);

  state_word_t           mem [MAX_GROUPS];
  state_word_t           rdata;
  logic [MAX_GROUPS-1:0] written;
  logic                  rvalid;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem[wb.idx] <= wb.word;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (wb.en) begin
        written[wb.idx] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= written[rd_idx];
      end
    end
  end

  assign rd_word = rvalid ? rdata : '0;

endmodule

>>> rtl/gtb_pipe.sv
// Refill, decision and write-back pipeline with output register.
module gtb_pipe import gtb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_load,
  input  req_t         in_req,
  input  state_word_t  rd_word,
  output wb_t          wb,
  output pipe_status_t status,
  gtb_res_if.source    res
);

  logic [PIPE_DEPTH:1]   v;
  logic [PIPE_DEPTH+1:1] free;
  item_t                 it [1:PIPE_DEPTH];
  item_t                 item_s1;

  logic [TOK_W-1:0]  r1_rate;
  logic [TIME_W-1:0] r2_delta;
  logic [TOK_W-1:0]  r2_rate;
  logic [P_W-1:0]    r2_bsc;
  logic [TIME_W-1:0] r3_pl;
  logic [TIME_W-1:0] r3_ph;
  logic [P_W-1:0]    r3_bsc;
  logic [PROD_W-1:0] r4_p;
  logic [P_W-1:0]    r4_bsc;
  logic              r5_sat;
  logic [P_W-1:0]    r5_p62;
  logic [A_W-1:0]    r5_a;
  logic [B_W-1:0]    r5_b;
  logic              r6_sat;
  logic [P_W-1:0]    r6_p62;
  logic [TOK_W-1:0]  r6_q;
  logic              r7_sat;
  logic [P_W-1:0]    r7_p62;
  logic [TOK_W-1:0]  r7_q;
  logic [P_W-1:0]    r7_qd;
  logic              r8_sat;
  logic [TOK_W-1:0]  r8_q;
  logic              r8_corr;
  logic [TOK_W-1:0]  r9_tokens;

  logic [S_W-1:0]       s5_sum;
  logic [P_W-1:0]       s7_rem;
  logic [TOK_EXT_W-1:0] s8_total;
  logic [TOK_W-1:0]     s8_tokens;
  logic                 s9_allow;
  logic [TOK_W-1:0]     s9_left;

  logic             out_valid;
  logic             out_allowed;
  logic [TOK_W-1:0] out_tokens_left;

  // A stage may take an item when it is empty or its own item moves on.
  always_comb begin
    free[PIPE_DEPTH+1] = !out_valid || res.ready;
    for (int k = PIPE_DEPTH; k >= 1; k--) begin
      free[k] = !v[k] || free[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (free[1]) begin
        v[1] <= in_load;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (free[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (free[PIPE_DEPTH+1]) begin
        out_valid <= v[PIPE_DEPTH];
      end
    end
  end

  always_comb begin
    item_s1         = it[1];
    item_s1.tok_old = rd_word.tokens;
  end

  // Carry the item descriptor down the stages.
  always_ff @(posedge clk) begin
    if (free[1]) begin
      it[1].lim     <= in_req.lim;
      it[1].idx     <= in_req.idx;
      it[1].bytes   <= in_req.bytes;
      it[1].now     <= in_req.now;
      it[1].bucket  <= in_req.bucket;
      it[1].tok_old <= '0;
      r1_rate       <= in_req.rate;
    end
    if (free[2]) begin
      it[2] <= item_s1;
    end
    for (int k = 3; k <= PIPE_DEPTH; k++) begin
      if (free[k]) begin
        it[k] <= it[k-1];
      end
    end
  end

  always_comb begin
    s5_sum    = {r5_b, {HALF_W{1'b0}}} + S_W'(r5_a);
    s7_rem    = r7_p62 - r7_qd;
    s8_total  = TOK_EXT_W'(r8_q) + TOK_EXT_W'(it[8].tok_old) + TOK_EXT_W'(r8_corr);
    s8_tokens = (r8_sat || (s8_total > TOK_EXT_W'(it[8].bucket))) ?
                it[8].bucket : s8_total[TOK_W-1:0];
    s9_allow  = it[PIPE_DEPTH].bytes <= r9_tokens;
    s9_left   = r9_tokens - it[PIPE_DEPTH].bytes;
  end

  always_ff @(posedge clk) begin
    // elapsed time modulo 2^64, and the bucket scaled to nanosecond units
    if (free[2]) begin
      r2_delta <= it[1].now - rd_word.last;
      r2_rate  <= r1_rate;
      r2_bsc   <= P_W'(it[1].bucket) * P_W'(NS_PER_SEC);
    end
    // elapsed times rate, in two halves
    if (free[3]) begin
      r3_pl  <= TIME_W'(r2_delta[HALF_W-1:0]) * TIME_W'(r2_rate);
      r3_ph  <= TIME_W'(r2_delta[TIME_W-1:HALF_W]) * TIME_W'(r2_rate);
      r3_bsc <= r2_bsc;
    end
    if (free[4]) begin
      r4_p   <= {r3_ph, {HALF_W{1'b0}}} + PROD_W'(r3_pl);
      r4_bsc <= r3_bsc;
    end
    // saturate when the refill alone reaches the bucket; start the quotient
    if (free[5]) begin
      r5_sat <= (r4_p[PROD_W-1:P_W] != '0) || (r4_p[P_W-1:0] >= r4_bsc);
      r5_p62 <= r4_p[P_W-1:0];
      r5_a   <= A_W'(r4_p[HALF_W-1:0]) * A_W'(RECIP);
      r5_b   <= B_W'(r4_p[P_W-1:HALF_W]) * B_W'(RECIP);
    end
    // estimate is the true quotient or one short of it
    if (free[6]) begin
      r6_sat <= r5_sat;
      r6_p62 <= r5_p62;
      r6_q   <= s5_sum[RECIP_SHIFT +: TOK_W];
    end
    if (free[7]) begin
      r7_sat <= r6_sat;
      r7_p62 <= r6_p62;
      r7_q   <= r6_q;
      r7_qd  <= P_W'(r6_q) * P_W'(NS_PER_SEC);
    end
    if (free[8]) begin
      r8_sat  <= r7_sat;
      r8_q    <= r7_q;
      r8_corr <= s7_rem >= P_W'(NS_PER_SEC);
    end
    if (free[9]) begin
      r9_tokens <= s8_tokens;
    end
    if (free[PIPE_DEPTH+1]) begin
      out_allowed     <= !it[PIPE_DEPTH].lim || s9_allow;
      out_tokens_left <= !it[PIPE_DEPTH].lim ? '0 :
                         (s9_allow ? s9_left : it[PIPE_DEPTH].tok_old);
    end
  end

  // Write back only an allowed limited item, as it leaves the last stage.
  always_comb begin
    wb.en          = v[PIPE_DEPTH] && free[PIPE_DEPTH+1] && it[PIPE_DEPTH].lim && s9_allow;
    wb.idx         = it[PIPE_DEPTH].idx;
    wb.word.tokens = s9_left;
    wb.word.last   = it[PIPE_DEPTH].now;
  end

  always_comb begin
    status.in_free = free[1];
    status.empty   = 1'b1;
    status.busy    = '0;
    for (int k = 1; k <= PIPE_DEPTH; k++) begin
      if (v[k]) begin
        status.empty = 1'b0;
      end
      if (v[k] && it[k].lim) begin
        status.busy[it[k].idx] = 1'b1;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.allowed     = out_allowed;
  assign res.tokens_left = out_tokens_left;

endmodule

>>> rtl/grouped_token_bucket_limiter.sv
// Top level of the grouped token bucket limiter.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------------------
//  req     | in  | valid / ready   | group_number, byte_count, time_now_ns
//  res     | out | valid / ready   | allowed, tokens_left
//  cfg     | in  | valid / ready   | index, data (rate 0..3, bucket 4..7)
//
// Nine pipeline stages (state read, elapsed time, two multiply stages,
// reciprocal divide by one billion with one correction step, refill cap,
// decision and write-back) lead to the output register. Items for different
// groups, or unlimited items, enter one per cycle unless a stalled result
// holds the pipeline; an item for a limited group that is already in flight
// waits until that item has written back, as set by the read-modify-write
// loop through the state memory. Reset clears the configuration and marks
// every group's state as zero. A stalled result holds in the output register
// while bubbles in the pipeline still close up and new items are taken as
// long as a bubble remains.
`include "grouped_token_bucket_limiter_assert.svh"

module grouped_token_bucket_limiter import gtb_pkg::*; (
  input logic        clk,
  input logic        rst,
  gtb_req_if.sink    req,
  gtb_res_if.source  res,
  gtb_cfg_if.sink    cfg
);

  logic [GIDX_W-1:0] req_idx;
  logic              req_in_range;
  logic              req_lim;
  logic              req_accept;
  logic [TOK_W-1:0]  lk_rate;
  logic [TOK_W-1:0]  lk_bucket;
  req_t              in_req;
  state_word_t       rd_word;
  wb_t               wb;
  pipe_status_t      st;

  // Group 0, groups beyond the configured count and zero-rate groups are
  // unlimited: they pass through the pipeline but never write the state.
  assign req_idx      = GIDX_W'(req.group_number - GRP_W'(1));
  assign req_in_range = (req.group_number != '0) &&
                        (req.group_number <= GRP_W'(NUM_GROUPS));
  assign req_lim      = req_in_range && (lk_rate != '0);

  // Hold a limited item back while its group still has an item in flight.
  assign req.ready  = st.in_free && !(req_lim && st.busy[req_idx]);
  assign req_accept = req.valid && req.ready;

  always_comb begin
    in_req.lim    = req_lim;
    in_req.idx    = req_idx;
    in_req.bytes  = req.byte_count;
    in_req.now    = req.time_now_ns;
    in_req.rate   = lk_rate;
    in_req.bucket = lk_bucket;
  end

  gtb_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .idx    (req_idx),
    .rate   (lk_rate),
    .bucket (lk_bucket)
  );

  // Read the group's state as the item is taken; data is ready in stage one.
  gtb_state_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_accept),
    .rd_idx  (req_idx),
    .rd_word (rd_word),
    .wb      (wb)
  );

  gtb_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .in_load (req_accept),
    .in_req  (in_req),
    .rd_word (rd_word),
    .wb      (wb),
    .status  (st),
    .res     (res)
  );

  // A write-back leaves no item of that group in flight.
  `GTB_ASSERT_NEXT(a_wb_group_free, clk, rst, wb.en, !st.busy[$past(wb.idx)])
  // A write-back always goes out as an allowed result.
  `GTB_ASSERT_NEXT(a_wb_allowed, clk, rst, wb.en, res.valid && res.allowed)
  // An accepted limited item marks its group busy.
  `GTB_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_accept && req_lim, st.busy[$past(req_idx)])
  // An empty block never refuses an item.
  `GTB_ASSERT_IMPLY(a_ready_when_idle, clk, rst, st.empty && !res.valid, req.ready)

endmodule
